[sv/wlcr_pkg.sv]
// Shared codes and field widths for the wear-leveled counter ring.
// No dependencies; imported by wear_leveled_counter_ring.
package wlcr_pkg;

  localparam int MODE_W  = 2;
  localparam int SEL_W   = 2;
  localparam int VALUE_W = 32;

  localparam logic [MODE_W-1:0] MODE_READ  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INC   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd3;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_BAD_SEL = 1'b1;

endpackage

[sv/wear_leveled_counter_ring.sv]
// Top level of the wear-leveled counter ring: slot memory, scan sequencer
// and result register. Depends on wlcr_pkg.
//
// Usage: the block holds NUM_COUNTERS counters, each kept as a ring of
// SLOTS_PER_COUNTER slots. The input channel (in_valid, in_stall, in_mode,
// in_counter_select, in_write_value) carries one operation per transaction:
// read, increment, write value or clear. Every input transaction produces
// exactly one output transaction (out_value, out_status).
// Read, increment and write scan the selected ring through the single read
// port of the slot memory, one slot per cycle, with one compare unit that
// tracks the largest value. A drain state then finishes the last compare,
// a write state writes the chosen slot for increment and write, and a done
// state loads the result into the output register once it is free. Clear
// and an invalid counter select go from acceptance straight to the done
// state. One operation is in flight at a time, so in_stall is high from
// acceptance until the result is loaded, and the block takes no new
// operation before it is through with the last one.
// While out_stall holds a finished result, the block still takes the next
// operation and runs it, and waits with its result until the output
// register frees up.
// Reset (rst_n low, synchronous) empties the output register and marks all
// slots invalid, so every slot reads as zero until written.
module wear_leveled_counter_ring
  import wlcr_pkg::*;
#(
  parameter int NUM_COUNTERS      = 3,
  parameter int SLOTS_PER_COUNTER = 8,
  parameter int SLOT_BITS         = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [MODE_W-1:0]  in_mode,
  input  logic [SEL_W-1:0]   in_counter_select,
  input  logic [VALUE_W-1:0] in_write_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [VALUE_W-1:0] out_value,
  output logic               out_status
);

  localparam int TOTAL_SLOTS = NUM_COUNTERS * SLOTS_PER_COUNTER;
  localparam int ADDR_W      = $clog2(TOTAL_SLOTS);
  localparam int IDX_W       = $clog2(SLOTS_PER_COUNTER);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS_PER_COUNTER - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_WRITE = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]           state_r;
  logic [MODE_W-1:0]    mode_r;
  logic [SEL_W-1:0]     sel_r;
  logic [SLOT_BITS-1:0] wval_r;
  logic [IDX_W-1:0]     idx_r;
  logic [IDX_W-1:0]     rd_idx_r;
  logic                 rd_go_r;
  logic [SLOT_BITS-1:0] best_r;
  logic [IDX_W-1:0]     at_r;
  logic                 found_r;
  logic [VALUE_W-1:0]   res_r;
  logic                 res_st_r;
  logic                 out_valid_r;
  logic [VALUE_W-1:0]   out_value_r;
  logic                 out_status_r;

  logic [SLOT_BITS-1:0] mem [TOTAL_SLOTS];
  logic [TOTAL_SLOTS-1:0] vld_r;
  logic [SLOT_BITS-1:0] rd_data_r;
  logic                 rd_vld_r;

  logic                 in_acc;
  logic                 out_free;
  logic                 sel_bad;
  logic [ADDR_W-1:0]    rd_addr;
  logic [ADDR_W-1:0]    wr_addr;
  logic [IDX_W-1:0]     next_idx;
  logic [SLOT_BITS-1:0] scan_val;
  logic [SLOT_BITS-1:0] wdata;
  logic [SLOT_BITS-1:0] new_max;
  logic                 mem_we;

  assign in_stall   = (state_r != ST_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign sel_bad    = int'(in_counter_select) >= NUM_COUNTERS;
  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

  assign rd_addr = ADDR_W'(int'(sel_r) * SLOTS_PER_COUNTER + int'(idx_r));

  // The next slot follows the first nonzero maximum, or is slot 0 if none.
  assign next_idx = !found_r ? '0 : (at_r == LAST_IDX) ? '0 : at_r + 1'b1;
  assign wr_addr  = ADDR_W'(int'(sel_r) * SLOTS_PER_COUNTER + int'(next_idx));

  assign scan_val = rd_vld_r ? rd_data_r : '0;
  assign wdata    = (mode_r == MODE_INC) ? best_r + 1'b1 : wval_r;
  assign mem_we   = (state_r == ST_WRITE) && (mode_r != MODE_READ);

  // The overwritten slot never held the sole copy of the maximum, so the
  // ring's new maximum is simply the larger of the old one and the new data.
  assign new_max  = (wdata > best_r) ? wdata : best_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= vld_r[rd_addr];
      if (in_acc && !sel_bad && in_mode == MODE_CLEAR) begin
        for (int j = 0; j < TOTAL_SLOTS; j++) begin
          if (j / SLOTS_PER_COUNTER == int'(in_counter_select)) begin
            vld_r[j] <= 1'b0;
          end
        end
      end else if (mem_we) begin
        vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_go_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      rd_go_r  <= (state_r == ST_SCAN);
      rd_idx_r <= idx_r;
      if (rd_go_r && scan_val > best_r) begin
        best_r  <= scan_val;
        at_r    <= rd_idx_r;
        found_r <= 1'b1;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            mode_r  <= in_mode;
            sel_r   <= in_counter_select;
            wval_r  <= SLOT_BITS'(in_write_value);
            idx_r   <= '0;
            best_r  <= '0;
            at_r    <= '0;
            found_r <= 1'b0;
            res_r   <= '0;
            if (sel_bad) begin
              res_st_r <= STATUS_BAD_SEL;
              state_r  <= ST_DONE;
            end else if (in_mode == MODE_CLEAR) begin
              res_st_r <= STATUS_OK;
              state_r  <= ST_DONE;
            end else begin
              res_st_r <= STATUS_OK;
              state_r  <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          idx_r <= idx_r + 1'b1;
          if (idx_r == LAST_IDX) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state_r <= ST_WRITE;
        end
        ST_WRITE: begin
          res_r   <= VALUE_W'((mode_r == MODE_READ) ? best_r : new_max);
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_value_r  <= res_r;
            out_status_r <= res_st_r;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_bad_sel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STATUS_BAD_SEL) |-> out_value == '0)
    else $error("invalid select result carries a nonzero value");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != ST_IDLE)
    else $error("accepted transaction did not start the sequencer");

  a_no_read_write: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (mode_r == MODE_INC || mode_r == MODE_WRITE))
    else $error("slot memory written for a read or clear");

  a_empty_ring_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRITE && !found_r) |-> best_r == '0)
    else $error("maximum nonzero although no slot was found");
`endif

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for wear_leveled_counter_ring: directed and random
// counter operations under random idling on both channels. Depends on wlcr_pkg.
module tb;
  import wlcr_pkg::*;

  localparam int NUM_RINGS = 3;
  localparam int SLOTS     = 8;
  localparam int SLOT_BITS = 32;
  localparam logic [VALUE_W-1:0] SLOT_MASK = {VALUE_W{1'b1}} >> (VALUE_W - SLOT_BITS);

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               status;
  } ring_result_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [MODE_W-1:0]  in_mode;
  logic [SEL_W-1:0]   in_counter_select;
  logic [VALUE_W-1:0] in_write_value;
  logic               out_valid;
  logic               out_stall;
  logic [VALUE_W-1:0] out_value;
  logic               out_status;

  // Shadow copy of the slot memory and results still owed by the block.
  logic [VALUE_W-1:0] slot_mem [NUM_RINGS][SLOTS];
  ring_result_t       expected_q [$];
  int                 mismatches;
  int                 hold_req;

  wear_leveled_counter_ring #(
    .NUM_COUNTERS      (NUM_RINGS),
    .SLOTS_PER_COUNTER (SLOTS),
    .SLOT_BITS         (SLOT_BITS)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_counter_select (in_counter_select),
    .in_write_value    (in_write_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_value         (out_value),
    .out_status        (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("[wear_leveled_counter_ring] ERROR");
    $finish;
  end

  // Finds the largest value of a ring and the slot after its first holder;
  // an all-zero ring points at slot 0.
  function automatic void scan_ring(input int ring, output logic [VALUE_W-1:0] peak,
                                    output int follow);
    int  at;
    bit  seen;
    peak = '0;
    at   = 0;
    seen = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_mem[ring][i] > peak) begin
        peak = slot_mem[ring][i];
        at   = i;
        seen = 1'b1;
      end
    end
    follow = !seen ? 0 : ((at + 1 == SLOTS) ? 0 : at + 1);
  endfunction

  function automatic ring_result_t apply_op(input logic [MODE_W-1:0] op_mode,
                                            input logic [SEL_W-1:0] sel,
                                            input logic [VALUE_W-1:0] wval);
    ring_result_t       res;
    logic [VALUE_W-1:0] peak;
    int                 follow;
    res.value  = '0;
    res.status = STATUS_OK;
    if (sel >= NUM_RINGS) begin
      res.status = STATUS_BAD_SEL;
      return res;
    end
    if (op_mode == MODE_CLEAR) begin
      for (int i = 0; i < SLOTS; i++) slot_mem[sel][i] = '0;
      return res;
    end
    scan_ring(int'(sel), peak, follow);
    if (op_mode == MODE_INC) begin
      slot_mem[sel][follow] = (peak + 1'b1) & SLOT_MASK;
    end else if (op_mode == MODE_WRITE) begin
      slot_mem[sel][follow] = wval & SLOT_MASK;
    end
    scan_ring(int'(sel), peak, follow);
    res.value = peak;
    return res;
  endfunction

  // Offers one transaction and holds it until the block takes it.
  task automatic send_op(input logic [MODE_W-1:0] op_mode, input logic [SEL_W-1:0] sel,
                         input logic [VALUE_W-1:0] wval);
    in_valid          <= 1'b1;
    in_mode           <= op_mode;
    in_counter_select <= sel;
    in_write_value    <= wval;
    do @(posedge clk); while (in_stall);
    expected_q.push_back(apply_op(op_mode, sel, wval));
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
  endtask

  always @(posedge clk) begin : result_check
    ring_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected transaction, expected none, got value %h status %b",
                 $time, out_value, out_status);
      end else begin
        want = expected_q.pop_front();
        if (out_value !== want.value) begin
          mismatches++;
          $display("%0t: value expected %h, got %h", $time, want.value, out_value);
        end
        if (out_status !== want.status) begin
          mismatches++;
          $display("%0t: status expected %b, got %b", $time, want.status, out_status);
        end
      end
    end
  end

  // Receiver: segments of random stall density, with a long hold-off on request.
  initial begin : receiver
    int seg_left;
    int stall_pct;
    int hold_left;
    seg_left  = 0;
    stall_pct = 0;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(200, 20);
          case ($urandom_range(3))
            0: stall_pct = 0;
            1: stall_pct = 30;
            2: stall_pct = 60;
            default: stall_pct = 85;
          endcase
        end
        seg_left--;
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic test_after_reset();
    for (int r = 0; r < 4; r++) send_op(MODE_READ, SEL_W'(r), '0);
    send_op(MODE_INC, SEL_W'(3), '0);
    send_op(MODE_WRITE, SEL_W'(3), 32'hFFFF_FFFF);
    send_op(MODE_CLEAR, SEL_W'(3), '0);
  endtask

  // Nine increments fill the ring and the ninth lands on slot 0 again.
  task automatic test_ring_wrap();
    repeat (SLOTS + 1) send_op(MODE_INC, SEL_W'(1), '0);
  endtask

  task automatic test_top_of_range();
    send_op(MODE_WRITE, SEL_W'(0), 32'hFFFF_FFFF);
    send_op(MODE_INC, SEL_W'(0), '0);
    send_op(MODE_WRITE, SEL_W'(0), 32'h0000_0005);
    send_op(MODE_READ, SEL_W'(0), '0);
    send_op(MODE_CLEAR, SEL_W'(0), '0);
    send_op(MODE_READ, SEL_W'(0), '0);
    send_op(MODE_WRITE, SEL_W'(2), '0);
  endtask

  // The receiver holds off while the sender keeps offering, so the block
  // parks one result, runs the next operation and then stalls its input.
  task automatic test_output_holdoff();
    wait_drain();
    hold_req = 80;
    for (int k = 0; k < 6; k++) send_op(MODE_INC, SEL_W'(k % NUM_RINGS), '0);
    wait_drain();
  endtask

  task automatic test_random_traffic(input int n_items);
    logic [MODE_W-1:0]  op_mode;
    logic [SEL_W-1:0]   sel;
    logic [VALUE_W-1:0] wval;
    logic [VALUE_W-1:0] peak;
    int                 follow;
    int                 pick;
    int                 burst_left;
    bit                 no_gaps;
    burst_left = $urandom_range(24, 1);
    no_gaps    = 1'b0;
    for (int k = 0; k < n_items; k++) begin
      if (k % 150 == 149) begin
        wait_drain();
        no_gaps = ($urandom_range(2) == 0);
      end
      if ($urandom_range(99) < 6) sel = SEL_W'(3);
      else sel = SEL_W'($urandom_range(NUM_RINGS - 1));
      pick = $urandom_range(99);
      if (pick < 40) op_mode = MODE_INC;
      else if (pick < 65) op_mode = MODE_READ;
      else if (pick < 97) op_mode = MODE_WRITE;
      else op_mode = MODE_CLEAR;
      peak = '0;
      if (sel < NUM_RINGS) scan_ring(int'(sel), peak, follow);
      case ($urandom_range(4))
        0: wval = $urandom();
        1: wval = peak + $urandom_range(3);
        2: wval = peak - $urandom_range(4, 1);
        3: begin
          case ($urandom_range(3))
            0: wval = '0;
            1: wval = 32'hFFFF_FFFF;
            2: wval = 32'hFFFF_FFFE;
            default: wval = 32'h0000_0001;
          endcase
        end
        default: wval = $urandom_range(255);
      endcase
      send_op(op_mode, sel, wval);
      burst_left--;
      if (burst_left == 0) begin
        idle_cycles(no_gaps ? 0 : $urandom_range(15, 1));
        burst_left = $urandom_range(24, 1);
      end
    end
  endtask

  initial begin
    for (int r = 0; r < NUM_RINGS; r++) begin
      for (int i = 0; i < SLOTS; i++) slot_mem[r][i] = '0;
    end
    mismatches        = 0;
    hold_req          = 0;
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_mode           <= MODE_READ;
    in_counter_select <= '0;
    in_write_value    <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_after_reset();
    test_ring_wrap();
    test_top_of_range();
    test_output_holdoff();
    test_random_traffic(1200);

    wait_drain();
    repeat (SLOTS + 10) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("[wear_leveled_counter_ring] OK");
    end else begin
      $display("[wear_leveled_counter_ring] ERROR");
    end
    $finish;
  end

endmodule
